// File: rtl/ftpc_pkg.sv
// ----------------------------------------------------------------------------
// Flow table package
// Shared types and constants for the exact-match flow table.
// ----------------------------------------------------------------------------
package ftpc_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int NUM_PORTS   = 16;
  localparam int KEY_BITS    = 32;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int PORT_IDX_W  = $clog2(NUM_PORTS);
  localparam int COUNT_W     = 9;

  localparam logic [1:0] CMD_INSTALL = 2'd0;
  localparam logic [1:0] CMD_REMOVE  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] flow_key;
    logic [3:0]  port;
    logic        last_in_batch;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         out_port;
    logic [COUNT_W-1:0] port_rule_count;
    logic [COUNT_W-1:0] entry_count;
    logic [31:0]        table_version;
  } out_item_t;

  // One word of the entry memory.
  typedef struct packed {
    logic                valid;
    logic [3:0]          port;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_APPLY,
    S_OUT
  } state_t;

endpackage

// File: rtl/ftpc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ftpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/flow_table_with_port_counts_core.sv
// ----------------------------------------------------------------------------
// Flow table with port counts
// Exact-match key to port table with per-port rule counts and a version.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_ready/in_item) carries install,
// remove and lookup transactions; one output channel (out_valid/out_ready/
// out_item) returns exactly one result per transaction, in order.
// Each transaction scans the entry memory (valid bit, port and key per word),
// one slot per cycle through its registered read port, looking for the key
// and the lowest free slot. The result is offered once the scan and the
// S_LAST, S_APPLY and S_OUT states are through. One item is in flight at a
// time, so no new transaction is accepted while one is being processed.
// After reset a clearing pass writes zero to every slot of the entry memory,
// and in_ready stays low until it is done. Port counts, the entry count and
// the version are flip-flops cleared by reset at once. A stalled receiver
// holds the result register; the next item is accepted once it is taken.
// ----------------------------------------------------------------------------
module flow_table_with_port_counts_core
  import ftpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  state_t state, state_next;
  in_item_t cur;
  logic [SLOT_W:0] idx;
  logic [SLOT_W-1:0] rd_slot;
  logic rd_pending;
  logic hit, hit_next;
  logic [SLOT_W-1:0] hit_slot;
  logic [3:0] hit_port;
  logic have_free;
  logic [SLOT_W-1:0] free_slot;
  logic [COUNT_W-1:0] rules [NUM_PORTS];
  logic [COUNT_W-1:0] entries;
  logic [31:0] version;
  logic changed;

  entry_t rd_entry;
  entry_t ram_wdata;
  logic ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [SLOT_W-1:0] wslot;
  logic [KEY_BITS-1:0] cur_key;

  assign cur_key = cur.flow_key[KEY_BITS-1:0];

  ftpc_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_entry_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(idx[SLOT_W-1:0]), .rdata(rd_entry));

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign hit_next = rd_pending && rd_entry.valid && (rd_entry.key == cur_key) && !hit;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (idx == (SLOT_W+1)'(TABLE_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:  if (in_valid && in_ready) state_next = S_SCAN;
      S_SCAN:  if (idx == (SLOT_W+1)'(TABLE_DEPTH - 1)) state_next = S_LAST;
      S_LAST:  state_next = S_APPLY;
      S_APPLY: state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Apply decision, made in S_APPLY after the scan completed.
  logic in_range;
  logic do_ins_new, do_move, do_remove, refuse, miss;
  assign in_range = 32'(cur.port) < NUM_PORTS;
  always_comb begin
    do_ins_new = 1'b0;
    do_move    = 1'b0;
    do_remove  = 1'b0;
    refuse     = 1'b0;
    miss       = 1'b0;
    case (cur.command)
      CMD_INSTALL: begin
        if (!in_range) refuse = 1'b1;
        else if (hit) do_move = (hit_port != cur.port);
        else if (have_free) do_ins_new = 1'b1;
        else refuse = 1'b1;
      end
      CMD_REMOVE: begin
        if (hit) do_remove = 1'b1;
        else miss = 1'b1;
      end
      CMD_LOOKUP: miss = !hit;
      default: ;
    endcase
  end

  assign wslot = do_ins_new ? free_slot : hit_slot;

  logic chg;
  assign chg = do_ins_new || do_move || do_remove;
  logic [PORT_IDX_W-1:0] old_idx, new_idx;
  assign old_idx = hit_port[PORT_IDX_W-1:0];
  assign new_idx = cur.port[PORT_IDX_W-1:0];

  // A remove writes an all-zero word; install and move write the full entry.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wslot;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx[SLOT_W-1:0];
      end
      S_APPLY: begin
        ram_we = chg;
        if (!do_remove) begin
          ram_wdata.valid = 1'b1;
          ram_wdata.port  = cur.port;
          ram_wdata.key   = cur_key;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      out_valid <= 1'b0;
      entries   <= '0;
      version   <= '0;
      changed   <= 1'b0;
      rd_pending <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) rules[i] <= '0;
    end else begin
      state <= state_next;
      rd_pending <= (state == S_SCAN);
      rd_slot <= idx[SLOT_W-1:0];
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur       <= in_item;
            idx       <= '0;
            hit       <= 1'b0;
            have_free <= 1'b0;
          end
        end
        S_SCAN, S_LAST: begin
          if (state == S_SCAN) begin
            idx <= idx + 1'b1;
          end
          if (rd_pending && !have_free && !rd_entry.valid) begin
            have_free <= 1'b1;
            free_slot <= rd_slot;
          end
          if (hit_next) begin
            hit      <= 1'b1;
            hit_slot <= rd_slot;
            hit_port <= rd_entry.port;
          end
        end
        S_APPLY: begin
          if (do_ins_new) begin
            entries <= entries + 1'b1;
            rules[new_idx] <= rules[new_idx] + 1'b1;
          end
          if (do_move) begin
            if (32'(hit_port) < NUM_PORTS && rules[old_idx] != '0)
              rules[old_idx] <= rules[old_idx] - 1'b1;
            rules[new_idx] <= rules[new_idx] + 1'b1;
          end
          if (do_remove) begin
            if (entries != '0) entries <= entries - 1'b1;
            if (32'(hit_port) < NUM_PORTS && rules[old_idx] != '0)
              rules[old_idx] <= rules[old_idx] - 1'b1;
          end
          if (cur.last_in_batch) begin
            if (changed || chg) version <= version + 1'b1;
            changed <= 1'b0;
          end else if (chg) begin
            changed <= 1'b1;
          end
          out_item.status <= refuse ? ST_FULL : (miss ? ST_MISSING : ST_OK);
          out_item.out_port <= (cur.command == CMD_LOOKUP && hit) ? hit_port : 4'd0;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_item.port_rule_count <= in_range ? rules[new_idx] : '0;
          out_item.entry_count <= entries;
          out_item.table_version <= version;
        end
        default: ;
      endcase
    end
  end

endmodule
